### sv/tpbbd_pkg.sv
// ----------------------------------------------------------------------------
// tpbbd_pkg
// Shared types, constants and small tables of the three-pass box blur core.
// ----------------------------------------------------------------------------
package tpbbd_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int PASS_COUNT_DEF = 3;

   localparam int PIX_W        = 8;
   localparam int DIM_W        = 9;
   localparam int RAD_W        = 6;
   localparam int BRIGHT_W     = 9;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 9;
   localparam int PR_W         = 5;
   localparam int SUM_W        = 14;
   localparam int RECIP_W      = 18;
   localparam int RECIP_SHIFT  = 19;
   localparam int PROD_W       = SUM_W + RECIP_W;
   localparam int RADIUS_LIMIT = 50;
   localparam int BRIGHT_ONE   = 256;
   localparam int THIRD_MUL    = 171;
   localparam int THIRD_SHIFT  = 9;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_RUN   = 2'd1,
      OP_FETCH = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_RADIUS = 2'd2,
      CSR_BRIGHT = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LINE,
      ST_INIT_RD,
      ST_INIT_ACC,
      ST_MUL,
      ST_WRITE,
      ST_SUB,
      ST_ADD,
      ST_DK_RD,
      ST_DK_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_we;
      logic fetch_rd;
      logic run_start;
      logic line_start;
      logic init_rd;
      logic init_acc;
      logic mul;
      logic wr_out;
      logic sub;
      logic add;
      logic line_next;
      logic phase_next;
      logic dk_start;
      logic dk_rd;
      logic dk_wr;
      logic rsp_pix;
      logic rsp_done;
   } cmd_type;

   typedef struct packed {
      logic k_done;
      logic x_last;
      logic line_last;
      logic pass_last;
      logic dk_last;
      logic rsp_free;
   } status_type;

   function automatic logic [PR_W-1:0] pass_radius(input logic [RAD_W-1:0] v);
      logic [RAD_W-1:0] c;
      logic [13:0]      p;
      logic [PR_W-1:0]  q;
      if (v == '0) c = RAD_W'(1);
      else if (v > RAD_W'(RADIUS_LIMIT)) c = RAD_W'(RADIUS_LIMIT);
      else c = v;
      p = 14'(c) * 14'(THIRD_MUL);
      q = p[THIRD_SHIFT +: PR_W];
      return (q == '0) ? PR_W'(1) : q;
   endfunction

   // ceil(2^19 / (2r+1))
   function automatic logic [RECIP_W-1:0] recip(input logic [PR_W-1:0] r);
      logic [RECIP_W-1:0] m;
      case (r)
         5'd2:    m = 18'd104858;
         5'd3:    m = 18'd74899;
         5'd4:    m = 18'd58255;
         5'd5:    m = 18'd47663;
         5'd6:    m = 18'd40330;
         5'd7:    m = 18'd34953;
         5'd8:    m = 18'd30841;
         5'd9:    m = 18'd27595;
         5'd10:   m = 18'd24967;
         5'd11:   m = 18'd22796;
         5'd12:   m = 18'd20972;
         5'd13:   m = 18'd19419;
         5'd14:   m = 18'd18079;
         5'd15:   m = 18'd16913;
         5'd16:   m = 18'd15888;
         default: m = 18'd174763;
      endcase
      return m;
   endfunction

endpackage

### sv/tpbbd_if.sv
// ----------------------------------------------------------------------------
// tpbbd_req_if / tpbbd_rsp_if
// Valid/ready channels of the blur core: request items and result items.
// ----------------------------------------------------------------------------
interface tpbbd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   modport source (output valid, op, red, green, blue, alpha, input ready);
   modport sink (input valid, op, red, green, blue, alpha, output ready);
endinterface

interface tpbbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [7:0] out_alpha;
   logic       last_pixel;
   logic       blur_done;
   modport source (output valid, out_red, out_green, out_blue, out_alpha, last_pixel,
                   blur_done, input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha, last_pixel,
                 blur_done, output ready);
endinterface

### sv/tpbbd_ram.sv
// ----------------------------------------------------------------------------
// tpbbd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tpbbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### sv/tpbbd_ctrl.sv
// ----------------------------------------------------------------------------
// tpbbd_ctrl
// Sequencer: request handshake, per-line blur steps, darken sweep, results.
// ----------------------------------------------------------------------------
module tpbbd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_op,
   output logic                   req_ready,
   input  tpbbd_pkg::status_type  status,
   output tpbbd_pkg::cmd_type     cmd
);
   tpbbd_pkg::state_type state_ff, state_in;
   tpbbd_pkg::op_type    op;

   assign op = tpbbd_pkg::op_type'(req_op);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpbbd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tpbbd_pkg::ST_IDLE: begin
            req_ready = (op == tpbbd_pkg::OP_LOAD) || (op == tpbbd_pkg::OP_NONE) ||
                        status.rsp_free;
            if (req_valid && req_ready) begin
               unique case (op)
                  tpbbd_pkg::OP_LOAD: cmd.load_we = 1'b1;
                  tpbbd_pkg::OP_FETCH: begin
                     cmd.fetch_rd = 1'b1;
                     state_in     = tpbbd_pkg::ST_FETCH;
                  end
                  tpbbd_pkg::OP_RUN: begin
                     cmd.run_start = 1'b1;
                     state_in      = tpbbd_pkg::ST_LINE;
                  end
                  default: ;
               endcase
            end
         end
         tpbbd_pkg::ST_FETCH: begin
            cmd.rsp_pix = 1'b1;
            state_in    = tpbbd_pkg::ST_IDLE;
         end
         tpbbd_pkg::ST_LINE: begin
            cmd.line_start = 1'b1;
            state_in       = tpbbd_pkg::ST_INIT_RD;
         end
         tpbbd_pkg::ST_INIT_RD: begin
            cmd.init_rd = 1'b1;
            state_in    = tpbbd_pkg::ST_INIT_ACC;
         end
         tpbbd_pkg::ST_INIT_ACC: begin
            cmd.init_acc = 1'b1;
            state_in     = status.k_done ? tpbbd_pkg::ST_MUL : tpbbd_pkg::ST_INIT_RD;
         end
         tpbbd_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = tpbbd_pkg::ST_WRITE;
         end
         tpbbd_pkg::ST_WRITE: begin
            cmd.wr_out = 1'b1;
            state_in   = tpbbd_pkg::ST_SUB;
         end
         tpbbd_pkg::ST_SUB: begin
            cmd.sub  = 1'b1;
            state_in = tpbbd_pkg::ST_ADD;
         end
         tpbbd_pkg::ST_ADD: begin
            cmd.add = 1'b1;
            if (!status.x_last) begin
               state_in = tpbbd_pkg::ST_MUL;
            end else if (!status.line_last) begin
               cmd.line_next = 1'b1;
               state_in      = tpbbd_pkg::ST_LINE;
            end else if (!status.pass_last) begin
               cmd.phase_next = 1'b1;
               state_in       = tpbbd_pkg::ST_LINE;
            end else begin
               cmd.dk_start = 1'b1;
               state_in     = tpbbd_pkg::ST_DK_RD;
            end
         end
         tpbbd_pkg::ST_DK_RD: begin
            cmd.dk_rd = 1'b1;
            state_in  = tpbbd_pkg::ST_DK_WR;
         end
         tpbbd_pkg::ST_DK_WR: begin
            cmd.dk_wr = 1'b1;
            state_in  = status.dk_last ? tpbbd_pkg::ST_DONE : tpbbd_pkg::ST_DK_RD;
         end
         tpbbd_pkg::ST_DONE: begin
            cmd.rsp_done = 1'b1;
            state_in     = tpbbd_pkg::ST_IDLE;
         end
         default: state_in = tpbbd_pkg::ST_IDLE;
      endcase
   end
endmodule

### sv/tpbbd_dp.sv
// ----------------------------------------------------------------------------
// tpbbd_dp
// Datapath: registers, frame stores, window sums, reciprocal divide, darken.
// ----------------------------------------------------------------------------
module tpbbd_dp #(
   parameter int MAX_WIDTH  = tpbbd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = tpbbd_pkg::MAX_HEIGHT_DEF,
   parameter int PASS_COUNT = tpbbd_pkg::PASS_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tpbbd_pkg::cmd_type                 cmd,
   output tpbbd_pkg::status_type              status,
   input  logic [tpbbd_pkg::PIX_W-1:0]        req_red,
   input  logic [tpbbd_pkg::PIX_W-1:0]        req_green,
   input  logic [tpbbd_pkg::PIX_W-1:0]        req_blue,
   input  logic [tpbbd_pkg::PIX_W-1:0]        req_alpha,
   input  logic                               csr_we,
   input  logic [tpbbd_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  logic [tpbbd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [tpbbd_pkg::PIX_W-1:0]        rsp_red,
   output logic [tpbbd_pkg::PIX_W-1:0]        rsp_green,
   output logic [tpbbd_pkg::PIX_W-1:0]        rsp_blue,
   output logic [tpbbd_pkg::PIX_W-1:0]        rsp_alpha,
   output logic                               rsp_last,
   output logic                               rsp_done
);
   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW     = $clog2(DEPTH);
   localparam int NW     = $clog2(DEPTH + 1);
   localparam int MAXDIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int LW     = $clog2(MAXDIM + 1);
   localparam int SW     = LW + 2;
   localparam int PW     = $clog2(PASS_COUNT + 1);
   localparam int PX     = 4 * tpbbd_pkg::PIX_W;
   localparam int P8     = tpbbd_pkg::PIX_W;

   logic [tpbbd_pkg::DIM_W-1:0]    width_ff, width_in, height_ff, height_in;
   logic [tpbbd_pkg::RAD_W-1:0]    radius_ff, radius_in;
   logic [tpbbd_pkg::BRIGHT_W-1:0] bright_ff, bright_in;

   logic [LW-1:0]                  w_eff, h_eff, len, lines;
   logic [NW-1:0]                  n;
   logic [tpbbd_pkg::PR_W-1:0]     r;
   logic [tpbbd_pkg::RECIP_W-1:0]  recip_m;
   logic [tpbbd_pkg::BRIGHT_W-1:0] bq;

   logic [AW-1:0] load_pos_ff, load_pos_in, fetch_pos_ff, fetch_pos_in;
   logic [AW-1:0] load_eff, fetch_eff;
   logic [NW-1:0] load_nxt, fetch_nxt;
   logic          fetch_last_ff, fetch_last_in;

   logic [PW-1:0]        pass_ff, pass_in;
   logic                 vert_ff, vert_in;
   logic [LW-1:0]        line_ff, line_in, x_ff, x_in;
   logic [AW-1:0]        lbase_ff, lbase_in;
   logic signed [SW-1:0] k_ff, k_in;
   logic [NW-1:0]        dk_ff, dk_in;

   logic [tpbbd_pkg::SUM_W-1:0]  sum_ff [4];
   logic [tpbbd_pkg::SUM_W-1:0]  sum_in [4];
   logic [tpbbd_pkg::PROD_W-1:0] prod_ff [4];
   logic [tpbbd_pkg::PROD_W-1:0] prod_in [4];

   logic       rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in, rsp_done_ff, rsp_done_in;
   logic [PX-1:0] rsp_pix_ff, rsp_pix_in;

   logic signed [SW-1:0] sidx, x_s, r_s, len_s;
   logic [LW-1:0]        cidx;
   logic [2*LW-1:0]      src_mul, dst_mul;
   logic [AW-1:0]        src_addr, dst_addr;

   logic [PX-1:0] pixel_q, scratch_q, rd_pix, mean, dk_data;
   logic [16:0]   scale_prod [3];

   logic          pix_we, scr_we;
   logic [AW-1:0] pix_waddr, pix_raddr;
   logic [PX-1:0] pix_wdata;

   // configuration and effective values
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      radius_in = radius_ff;
      bright_in = bright_ff;
      if (csr_we) begin
         unique case (tpbbd_pkg::csr_idx_type'(csr_idx))
            tpbbd_pkg::CSR_WIDTH:  width_in  = csr_wdata[tpbbd_pkg::DIM_W-1:0];
            tpbbd_pkg::CSR_HEIGHT: height_in = csr_wdata[tpbbd_pkg::DIM_W-1:0];
            tpbbd_pkg::CSR_RADIUS: radius_in = csr_wdata[tpbbd_pkg::RAD_W-1:0];
            tpbbd_pkg::CSR_BRIGHT: bright_in = csr_wdata[tpbbd_pkg::BRIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) w_eff = LW'(1);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = LW'(MAX_WIDTH);
      else w_eff = LW'(width_ff);
      if (height_ff == '0) h_eff = LW'(1);
      else if (32'(height_ff) > MAX_HEIGHT) h_eff = LW'(MAX_HEIGHT);
      else h_eff = LW'(height_ff);
      n       = NW'(NW'(w_eff) * NW'(h_eff));
      r       = tpbbd_pkg::pass_radius(radius_ff);
      recip_m = tpbbd_pkg::recip(r);
      bq      = (bright_ff > tpbbd_pkg::BRIGHT_W'(tpbbd_pkg::BRIGHT_ONE)) ?
                tpbbd_pkg::BRIGHT_W'(tpbbd_pkg::BRIGHT_ONE) : bright_ff;
      len     = vert_ff ? h_eff : w_eff;
      lines   = vert_ff ? w_eff : h_eff;
   end

   // load and fetch positions
   always_comb begin
      load_eff  = (NW'(load_pos_ff) >= n) ? '0 : load_pos_ff;
      fetch_eff = (NW'(fetch_pos_ff) >= n) ? '0 : fetch_pos_ff;
      load_nxt  = NW'(load_eff) + NW'(1);
      fetch_nxt = NW'(fetch_eff) + NW'(1);
   end

   // window addresses
   always_comb begin
      x_s   = signed'(SW'(x_ff));
      r_s   = signed'(SW'(r));
      len_s = signed'(SW'(len));
      if (cmd.init_rd) sidx = k_ff;
      else if (cmd.wr_out) sidx = x_s - r_s;
      else sidx = x_s + r_s + SW'(1);
      if (sidx < 0) cidx = '0;
      else if (sidx >= len_s) cidx = len - LW'(1);
      else cidx = sidx[LW-1:0];
      src_mul  = (2*LW)'(cidx) * (2*LW)'(w_eff);
      dst_mul  = (2*LW)'(x_ff) * (2*LW)'(w_eff);
      src_addr = lbase_ff + (vert_ff ? AW'(src_mul) : AW'(cidx));
      dst_addr = lbase_ff + (vert_ff ? AW'(dst_mul) : AW'(x_ff));
   end

   always_comb begin
      rd_pix = vert_ff ? scratch_q : pixel_q;
      for (int c = 0; c < 4; c++) begin
         mean[P8*c +: P8] = prod_ff[c][tpbbd_pkg::RECIP_SHIFT +: P8];
      end
      for (int c = 0; c < 3; c++) begin
         scale_prod[c]       = 17'(pixel_q[P8*c +: P8]) * 17'(bq);
         dk_data[P8*c +: P8] = scale_prod[c][P8 +: P8];
      end
      dk_data[P8*3 +: P8] = pixel_q[P8*3 +: P8];
   end

   // sequencing registers
   always_comb begin
      load_pos_in   = load_pos_ff;
      fetch_pos_in  = fetch_pos_ff;
      fetch_last_in = fetch_last_ff;
      pass_in       = pass_ff;
      vert_in       = vert_ff;
      line_in       = line_ff;
      x_in          = x_ff;
      lbase_in      = lbase_ff;
      k_in          = k_ff;
      dk_in         = dk_ff;
      sum_in        = sum_ff;
      prod_in       = prod_ff;
      if (cmd.load_we) begin
         load_pos_in = (load_nxt >= n) ? '0 : AW'(load_nxt);
      end
      if (cmd.fetch_rd) begin
         fetch_pos_in  = (fetch_nxt >= n) ? '0 : AW'(fetch_nxt);
         fetch_last_in = (fetch_nxt == n);
      end
      if (cmd.rsp_done) begin
         load_pos_in  = '0;
         fetch_pos_in = '0;
      end
      if (cmd.run_start) begin
         pass_in  = '0;
         vert_in  = 1'b0;
         line_in  = '0;
         lbase_in = '0;
      end
      if (cmd.line_start) begin
         k_in = -r_s;
         x_in = '0;
         for (int c = 0; c < 4; c++) sum_in[c] = '0;
      end
      if (cmd.init_acc) begin
         k_in = k_ff + SW'(1);
         for (int c = 0; c < 4; c++) begin
            sum_in[c] = sum_ff[c] + tpbbd_pkg::SUM_W'(rd_pix[P8*c +: P8]);
         end
      end
      if (cmd.mul) begin
         for (int c = 0; c < 4; c++) begin
            prod_in[c] = tpbbd_pkg::PROD_W'(sum_ff[c]) * tpbbd_pkg::PROD_W'(recip_m);
         end
      end
      if (cmd.sub) begin
         for (int c = 0; c < 4; c++) begin
            sum_in[c] = sum_ff[c] - tpbbd_pkg::SUM_W'(rd_pix[P8*c +: P8]);
         end
      end
      if (cmd.add) begin
         x_in = x_ff + LW'(1);
         for (int c = 0; c < 4; c++) begin
            sum_in[c] = sum_ff[c] + tpbbd_pkg::SUM_W'(rd_pix[P8*c +: P8]);
         end
      end
      if (cmd.line_next) begin
         line_in  = line_ff + LW'(1);
         lbase_in = lbase_ff + (vert_ff ? AW'(1) : AW'(w_eff));
      end
      if (cmd.phase_next) begin
         line_in  = '0;
         lbase_in = '0;
         vert_in  = !vert_ff;
         if (vert_ff) pass_in = pass_ff + PW'(1);
      end
      if (cmd.dk_start) dk_in = '0;
      if (cmd.dk_wr) dk_in = dk_ff + NW'(1);
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pix_in   = rsp_pix_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      if (cmd.rsp_pix) begin
         rsp_valid_in = 1'b1;
         rsp_pix_in   = pixel_q;
         rsp_last_in  = fetch_last_ff;
         rsp_done_in  = 1'b0;
      end else if (cmd.rsp_done) begin
         rsp_valid_in = 1'b1;
         rsp_pix_in   = '0;
         rsp_last_in  = 1'b0;
         rsp_done_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= tpbbd_pkg::DIM_W'(256);
         height_ff    <= tpbbd_pkg::DIM_W'(256);
         radius_ff    <= tpbbd_pkg::RAD_W'(1);
         bright_ff    <= tpbbd_pkg::BRIGHT_W'(tpbbd_pkg::BRIGHT_ONE);
         load_pos_ff  <= '0;
         fetch_pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         radius_ff    <= radius_in;
         bright_ff    <= bright_in;
         load_pos_ff  <= load_pos_in;
         fetch_pos_ff <= fetch_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fetch_last_ff <= fetch_last_in;
      pass_ff       <= pass_in;
      vert_ff       <= vert_in;
      line_ff       <= line_in;
      x_ff          <= x_in;
      lbase_ff      <= lbase_in;
      k_ff          <= k_in;
      dk_ff         <= dk_in;
      sum_ff        <= sum_in;
      prod_ff       <= prod_in;
      rsp_pix_ff    <= rsp_pix_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_done_ff   <= rsp_done_in;
   end

   // frame stores
   always_comb begin
      pix_we    = cmd.load_we || cmd.dk_wr || (cmd.wr_out && vert_ff);
      scr_we    = cmd.wr_out && !vert_ff;
      if (cmd.load_we) begin
         pix_waddr = load_eff;
         pix_wdata = {req_alpha, req_blue, req_green, req_red};
      end else if (cmd.dk_wr) begin
         pix_waddr = AW'(dk_ff);
         pix_wdata = dk_data;
      end else begin
         pix_waddr = dst_addr;
         pix_wdata = mean;
      end
      if (cmd.fetch_rd) pix_raddr = fetch_eff;
      else if (cmd.dk_rd) pix_raddr = AW'(dk_ff);
      else pix_raddr = src_addr;
   end

   tpbbd_ram #(.WIDTH(PX), .DEPTH(DEPTH)) u_pixel_ram (
      .clock (clock),
      .we    (pix_we),
      .waddr (pix_waddr),
      .wdata (pix_wdata),
      .raddr (pix_raddr),
      .rdata (pixel_q)
   );

   tpbbd_ram #(.WIDTH(PX), .DEPTH(DEPTH)) u_scratch_ram (
      .clock (clock),
      .we    (scr_we),
      .waddr (dst_addr),
      .wdata (mean),
      .raddr (src_addr),
      .rdata (scratch_q)
   );

   always_comb begin
      status.k_done    = (k_ff == r_s);
      status.x_last    = (x_ff == len - LW'(1));
      status.line_last = (line_ff == lines - LW'(1));
      status.pass_last = vert_ff && (pass_ff == PW'(PASS_COUNT - 1));
      status.dk_last   = (dk_ff == n - NW'(1));
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_pix_ff[0 +: P8];
   assign rsp_green = rsp_pix_ff[P8 +: P8];
   assign rsp_blue  = rsp_pix_ff[2*P8 +: P8];
   assign rsp_alpha = rsp_pix_ff[3*P8 +: P8];
   assign rsp_last  = rsp_last_ff;
   assign rsp_done  = rsp_done_ff;
endmodule

### sv/three_pass_box_blur_darken_core.sv
// ----------------------------------------------------------------------------
// three_pass_box_blur_darken_core
// Loads an RGBA8 frame, blurs it with repeated box passes, darkens, fetches.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  req_bus   in   valid/ready        op, red, green, blue, alpha
//  rsp_bus   out  valid/ready        out_red..out_alpha, last_pixel, blur_done
//  csr_*     in   csr_we only        csr_idx, csr_wdata
//
//  Load writes the pixel store when taken. Fetch goes through a registered
//  frame-store read. Run time is set by the single read port of each frame
//  store (one read per window step, for both output and darkened pixels).
//  Reset is synchronous; the frame stores are not cleared.
//  A fetch or run waits while the result register is full and not taken.
// ----------------------------------------------------------------------------
module three_pass_box_blur_darken_core #(
   parameter int MAX_WIDTH  = tpbbd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = tpbbd_pkg::MAX_HEIGHT_DEF,
   parameter int PASS_COUNT = tpbbd_pkg::PASS_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   tpbbd_req_if.sink                        req_bus,
   tpbbd_rsp_if.source                      rsp_bus,
   input  logic                             csr_we,
   input  logic [tpbbd_pkg::CSR_IDX_W-1:0]  csr_idx,
   input  logic [tpbbd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   tpbbd_pkg::cmd_type    cmd;
   tpbbd_pkg::status_type status;

   tpbbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.op),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tpbbd_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PASS_COUNT (PASS_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_red   (req_bus.red),
      .req_green (req_bus.green),
      .req_blue  (req_bus.blue),
      .req_alpha (req_bus.alpha),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_red   (rsp_bus.out_red),
      .rsp_green (rsp_bus.out_green),
      .rsp_blue  (rsp_bus.out_blue),
      .rsp_alpha (rsp_bus.out_alpha),
      .rsp_last  (rsp_bus.last_pixel),
      .rsp_done  (rsp_bus.blur_done)
   );
endmodule

### sv/tpbbd_checker.sv
// ----------------------------------------------------------------------------
// tpbbd_checker
// Port-level checks of the blur core, bound to the top level.
// ----------------------------------------------------------------------------
module tpbbd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_op,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic [7:0] rsp_alpha,
   input logic       rsp_last,
   input logic       rsp_done
);
   logic fetch_xfer, run_xfer;

   assign fetch_xfer = req_valid && req_ready && (req_op == tpbbd_pkg::OP_FETCH);
   assign run_xfer   = req_valid && req_ready && (req_op == tpbbd_pkg::OP_RUN);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_done))
      else $error("result changed while stalled");

   a_done_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done |-> rsp_red == 8'd0 && rsp_green == 8'd0 &&
      rsp_blue == 8'd0 && rsp_alpha == 8'd0 && !rsp_last)
      else $error("run result carries pixel data");

   a_fetch_rsp: assert property (@(posedge clock) disable iff (reset)
      fetch_xfer |=> ##1 rsp_valid && !rsp_done)
      else $error("fetch transfer gave no pixel result");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      run_xfer |=> !req_ready)
      else $error("request taken while blur runs");
endmodule

bind three_pass_box_blur_darken_core tpbbd_checker u_tpbbd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_op    (req_bus.op),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_red   (rsp_bus.out_red),
   .rsp_green (rsp_bus.out_green),
   .rsp_blue  (rsp_bus.out_blue),
   .rsp_alpha (rsp_bus.out_alpha),
   .rsp_last  (rsp_bus.last_pixel),
   .rsp_done  (rsp_bus.blur_done)
);

### dv/tb_three_pass_box_blur_darken_core.sv
// ----------------------------------------------------------------------------
// tb_three_pass_box_blur_darken_core
// Self-checking bench for the box blur core. Frames are loaded, blurred and
// fetched back under several frame sizes, radii and brightness settings. A
// behavioral frame model predicts every result, and results are checked in
// order. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_three_pass_box_blur_darken_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 65536;

   typedef struct packed {
      tpbbd_pkg::op_type op;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic [7:0]        alpha;
      logic              hold;
   } px_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last;
      logic       done;
   } px_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [tpbbd_pkg::CSR_IDX_W-1:0]  csr_idx = '0;
   logic [tpbbd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   tpbbd_req_if req_bus();
   tpbbd_rsp_if rsp_bus();

   three_pass_box_blur_darken_core dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   px_req_type pend_q[$];
   px_rsp_type pix_expect[$];
   int      errors = 0;
   bit      quiet = 1'b0;
   bit      req_fire = 1'b0;

   // frame model
   bit [31:0]   frame_mem [DEPTH];
   bit [31:0]   scratch_mem [DEPTH];
   int unsigned ld_pos = 0, ft_pos = 0;
   int unsigned cfg_w = 256, cfg_h = 256, cfg_rad = 1, cfg_br = 256;

   // generator shadow
   bit          written [DEPTH];
   int unsigned gen_ld = 0, gen_n = 0, gen_cnt = 0, n_items = 0;

   function automatic int unsigned eff_w();
      return (cfg_w < 1) ? 1 : (cfg_w > 256) ? 256 : cfg_w;
   endfunction

   function automatic int unsigned eff_h();
      return (cfg_h < 1) ? 1 : (cfg_h > 256) ? 256 : cfg_h;
   endfunction

   function automatic int unsigned clamp_idx(int i, int unsigned len);
      if (i < 0) return 0;
      if (i >= int'(len)) return len - 1;
      return i;
   endfunction

   function automatic void blur_line(bit to_scratch, int unsigned base, int unsigned stride,
                                     int unsigned len, int unsigned r);
      int unsigned sum [4];
      int unsigned dv, x, c, o;
      bit [31:0]   p, pl, pr, q;
      dv = 2 * r + 1;
      for (c = 0; c < 4; c++) sum[c] = 0;
      for (int k = -int'(r); k <= int'(r); k++) begin
         o = base + clamp_idx(k, len) * stride;
         p = to_scratch ? frame_mem[o] : scratch_mem[o];
         for (c = 0; c < 4; c++) sum[c] += p[8*c +: 8];
      end
      for (x = 0; x < len; x++) begin
         for (c = 0; c < 4; c++) q[8*c +: 8] = 8'(sum[c] / dv);
         o = base + x * stride;
         if (to_scratch) scratch_mem[o] = q;
         else frame_mem[o] = q;
         o = base + clamp_idx(int'(x) - int'(r), len) * stride;
         pl = to_scratch ? frame_mem[o] : scratch_mem[o];
         o = base + clamp_idx(int'(x) + int'(r) + 1, len) * stride;
         pr = to_scratch ? frame_mem[o] : scratch_mem[o];
         for (c = 0; c < 4; c++) sum[c] = sum[c] + pr[8*c +: 8] - pl[8*c +: 8];
      end
   endfunction

   function automatic void blur_frame();
      int unsigned w, h, r, b, i, c;
      bit [31:0]   p;
      w = eff_w();
      h = eff_h();
      r = (cfg_rad < 1) ? 1 : (cfg_rad > 50) ? 50 : cfg_rad;
      r = r / 3;
      if (r < 1) r = 1;
      b = (cfg_br > 256) ? 256 : cfg_br;
      for (int pass = 0; pass < tpbbd_pkg::PASS_COUNT_DEF; pass++) begin
         for (i = 0; i < h; i++) blur_line(1'b1, i * w, 1, w, r);
         for (i = 0; i < w; i++) blur_line(1'b0, i, w, h, r);
      end
      for (i = 0; i < w * h; i++) begin
         p = frame_mem[i];
         for (c = 0; c < 3; c++) p[8*c +: 8] = 8'((p[8*c +: 8] * b) >> 8);
         frame_mem[i] = p;
      end
   endfunction

   // predict at the accepting edge
   always @(posedge clock) begin
      int unsigned n;
      bit [31:0]   p;
      px_rsp_type  e;
      req_fire = req_bus.valid && req_bus.ready && !reset;
      if (req_fire) begin
         n = eff_w() * eff_h();
         case (tpbbd_pkg::op_type'(req_bus.op))
            tpbbd_pkg::OP_LOAD: begin
               if (ld_pos >= n) ld_pos = 0;
               frame_mem[ld_pos] = {req_bus.alpha, req_bus.blue, req_bus.green, req_bus.red};
               ld_pos++;
               if (ld_pos >= n) ld_pos = 0;
            end
            tpbbd_pkg::OP_RUN: begin
               blur_frame();
               ld_pos = 0;
               ft_pos = 0;
               pix_expect.push_back('{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1});
            end
            tpbbd_pkg::OP_FETCH: begin
               if (ft_pos >= n) ft_pos = 0;
               p = frame_mem[ft_pos];
               e = '{p[7:0], p[15:8], p[23:16], p[31:24], ft_pos == n - 1, 1'b0};
               pix_expect.push_back(e);
               ft_pos++;
               if (ft_pos >= n) ft_pos = 0;
            end
            default: ;
         endcase
      end
   end

   // check results
   always @(posedge clock) begin
      px_rsp_type a, e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         a = '{rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue, rsp_bus.out_alpha,
               rsp_bus.last_pixel, rsp_bus.blur_done};
         if (pix_expect.size() == 0) begin
            $display("%0t: unexpected transfer, actual %h", $realtime, a);
            errors++;
         end else begin
            e = pix_expect.pop_front();
            if (a !== e) begin
               $display("%0t: mismatch r/g/b/a/last/done expected %h actual %h",
                        $realtime, e, a);
               errors++;
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      px_req_type it;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (pend_q.size() == 0 || (!quiet && $urandom_range(99) < 26) ||
             (pend_q[0].hold && pix_expect.size() != 0)) begin
            req_bus.valid <= 1'b0;
         end else begin
            it = pend_q.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.op    <= it.op;
            req_bus.red   <= it.red;
            req_bus.green <= it.green;
            req_bus.blue  <= it.blue;
            req_bus.alpha <= it.alpha;
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= quiet || ($urandom_range(99) >= 26);
   end

   task automatic push_item(tpbbd_pkg::op_type op, bit hold = 1'b0);
      px_req_type it;
      it = '{op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), hold};
      if ($urandom_range(9) == 0) it.red = 8'hFF;
      if ($urandom_range(9) == 0) it.alpha = 8'h00;
      pend_q.push_back(it);
      if (op != tpbbd_pkg::OP_NONE) n_items++;
      if (op == tpbbd_pkg::OP_LOAD) begin
         if (gen_ld >= gen_n) gen_ld = 0;
         if (!written[gen_ld]) begin
            written[gen_ld] = 1'b1;
            gen_cnt++;
         end
         gen_ld++;
         if (gen_ld >= gen_n) gen_ld = 0;
      end else if (op == tpbbd_pkg::OP_RUN) begin
         gen_ld = 0;
      end
   endtask

   task automatic wait_drained();
      wait (pend_q.size() == 0 && !req_bus.valid && pix_expect.size() == 0);
      repeat (40) @(negedge clock);
   endtask

   task automatic set_frame(int unsigned w, int unsigned h, int unsigned r, int unsigned b);
      wait_drained();
      csr_we <= 1'b1;
      csr_idx <= tpbbd_pkg::CSR_WIDTH;  csr_wdata <= tpbbd_pkg::CSR_DATA_W'(w);
      @(negedge clock);
      csr_idx <= tpbbd_pkg::CSR_HEIGHT; csr_wdata <= tpbbd_pkg::CSR_DATA_W'(h);
      @(negedge clock);
      csr_idx <= tpbbd_pkg::CSR_RADIUS; csr_wdata <= tpbbd_pkg::CSR_DATA_W'(r);
      @(negedge clock);
      csr_idx <= tpbbd_pkg::CSR_BRIGHT; csr_wdata <= tpbbd_pkg::CSR_DATA_W'(b);
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_w = w; cfg_h = h; cfg_rad = r & 6'h3F; cfg_br = b;
      gen_n = eff_w() * eff_h();
      gen_cnt = 0;
      for (int i = 0; i < gen_n; i++) gen_cnt += written[i];
   endtask

   task automatic fill_frame();
      while (gen_cnt < gen_n) push_item(tpbbd_pkg::OP_LOAD);
   endtask

   task automatic random_phase(int unsigned len);
      int unsigned k;
      fill_frame();
      if ($urandom_range(9) < 7) push_item(tpbbd_pkg::OP_RUN, $urandom_range(3) == 0);
      for (int i = 0; i < len; i++) begin
         k = $urandom_range(99);
         if (gen_cnt < gen_n) push_item(k < 90 ? tpbbd_pkg::OP_LOAD : tpbbd_pkg::OP_NONE);
         else if (k < 2) push_item(tpbbd_pkg::OP_RUN);
         else if (k < 50) push_item(tpbbd_pkg::OP_FETCH, k == 10);
         else if (k < 94) push_item(tpbbd_pkg::OP_LOAD);
         else push_item(tpbbd_pkg::OP_NONE);
      end
   endtask

   initial begin
      int unsigned w, h, ph;
      req_bus.valid = 1'b0;
      req_bus.op = tpbbd_pkg::OP_NONE;
      req_bus.red = '0; req_bus.green = '0; req_bus.blue = '0; req_bus.alpha = '0;
      rsp_bus.ready = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: tiny frame, extremes, wrap of fetch, ignored op
      set_frame(2, 2, 1, 256);
      pend_q.push_back('{tpbbd_pkg::OP_LOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0});
      pend_q.push_back('{tpbbd_pkg::OP_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0});
      pend_q.push_back('{tpbbd_pkg::OP_NONE, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0});
      pend_q.push_back('{tpbbd_pkg::OP_LOAD, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0});
      pend_q.push_back('{tpbbd_pkg::OP_LOAD, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0});
      for (int i = 0; i < 4; i++) written[i] = 1'b1;
      pend_q.push_back('{tpbbd_pkg::OP_FETCH, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0});
      pend_q.push_back('{tpbbd_pkg::OP_RUN, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0});
      for (int i = 0; i < 5; i++) begin
         pend_q.push_back('{tpbbd_pkg::OP_FETCH, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0});
      end
      // zero width, radius past limit, brightness zero
      set_frame(0, 3, 63, 0);
      fill_frame();
      push_item(tpbbd_pkg::OP_RUN, 1'b1);
      push_item(tpbbd_pkg::OP_FETCH); push_item(tpbbd_pkg::OP_FETCH);
      push_item(tpbbd_pkg::OP_LOAD); push_item(tpbbd_pkg::OP_LOAD);
      // shrink below both positions, oversized brightness
      set_frame(1, 1, 0, 511);
      push_item(tpbbd_pkg::OP_FETCH); push_item(tpbbd_pkg::OP_LOAD);
      push_item(tpbbd_pkg::OP_RUN); push_item(tpbbd_pkg::OP_FETCH);
      // widest row and tallest column
      set_frame(511, 1, 50, 255);
      fill_frame(); push_item(tpbbd_pkg::OP_RUN); push_item(tpbbd_pkg::OP_FETCH);
      set_frame(1, 256, 49, 128);
      fill_frame(); push_item(tpbbd_pkg::OP_RUN, 1'b1); push_item(tpbbd_pkg::OP_FETCH);

      ph = 0;
      while (n_items < 2000) begin
         w = ($urandom_range(19) == 0) ? (($urandom_range(1)) ? 256 : 300 + $urandom_range(211))
                                       : $urandom_range(12);
         h = (w > 12) ? $urandom_range(1) : ($urandom_range(19) == 0) ? 256 + $urandom_range(255)
                                                                       : $urandom_range(12);
         if (h > 12) w = $urandom_range(1);
         quiet = (ph >= 5 && ph < 9);
         set_frame(w, h, $urandom_range(63), ($urandom_range(7) == 0) ? 256 : $urandom_range(511));
         random_phase($urandom_range(40, 150));
         ph++;
      end
      wait_drained();
      repeat (100) @(negedge clock);
      if (errors == 0) $display("tb_three_pass_box_blur_darken_core: PASS");
      else $display("tb_three_pass_box_blur_darken_core: FAIL");
      $finish;
   end

   initial begin
      #40ms;
      $display("tb_three_pass_box_blur_darken_core: FAIL");
      $finish;
   end

endmodule
